// ===== rtl/rsr_pkg.sv =====
// rsr_pkg: widths, types and helper functions for the ray/segment range finder.
// No dependencies; every other rtl file imports it.
`default_nettype none

package rsr_pkg;

    // Fixed-point and field widths
    localparam int FRAC_BITS = 8;
    localparam int SEG_W     = 16;
    localparam int CRD_W     = 24;
    localparam int RANGE_W   = 25;
    localparam logic [RANGE_W-1:0] RANGE_MAX = {RANGE_W{1'b1}};

    // APB register file
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;
    localparam logic [1:0] REG_SEG_SX = 2'd0;
    localparam logic [1:0] REG_SEG_SY = 2'd1;
    localparam logic [1:0] REG_SEG_EX = 2'd2;
    localparam logic [1:0] REG_SEG_EY = 2'd3;

    // Datapath widths
    localparam int UX_W   = SEG_W + 1;
    localparam int V_W    = CRD_W + 1;
    localparam int AX_W   = SEG_W + FRAC_BITS;
    localparam int W_W    = ((AX_W > CRD_W) ? AX_W : CRD_W) + 1;
    localparam int TDP_W  = UX_W + V_W;
    localparam int TNP_W  = W_W + V_W;
    localparam int DEN_W  = TDP_W + 1 + FRAC_BITS;
    localparam int TN_W   = TNP_W + 1;
    localparam int HALF_W = DEN_W / 2;
    localparam int N_W    = UX_W + TN_W + 2;
    localparam int NMAG_W = N_W - 1;
    localparam int Q_W    = SEG_W + 3;
    localparam int PX_W   = Q_W + 1;
    localparam int PD_W   = PX_W + FRAC_BITS + 1;
    localparam int DX_W   = CRD_W + 1;
    localparam int SQ_IN_W  = 2 * CRD_W + 1;
    localparam int SQ_STEPS = CRD_W + 1;
    localparam int SQ_R_W   = SQ_IN_W + 1;

    typedef logic signed [CRD_W-1:0] t_crd;
    typedef logic signed [SEG_W-1:0] t_seg;

    typedef struct packed {
        t_seg sx;
        t_seg sy;
        t_seg ex;
        t_seg ey;
    } t_seg_cfg;

    typedef struct packed {
        t_crd ox;
        t_crd oy;
        t_crd ex;
        t_crd ey;
    } t_ray;

    typedef struct packed {
        logic miss;
        t_ray ray;
    } t_side;

    // front end to divider lanes
    typedef struct packed {
        t_side              side;
        logic               nx_neg;
        logic [NMAG_W-1:0]  nx_mag;
        logic               ny_neg;
        logic [NMAG_W-1:0]  ny_mag;
        logic [DEN_W-1:0]   dvs;
    } t_frt;

    typedef struct packed {
        logic               hit;
        logic [RANGE_W-1:0] range;
    } t_res;

    // ray box wholly on one side of the segment span
    function automatic logic box_miss(input logic signed [W_W-1:0] o,
                                      input logic signed [W_W-1:0] e,
                                      input logic signed [W_W-1:0] a,
                                      input logic signed [W_W-1:0] b);
        return (o < a && o < b && e < a && e < b) ||
               (o > a && o > b && e > a && e > b);
    endfunction

    // point outside the span [a, b] in either order
    function automatic logic outside(input logic signed [PD_W-1:0] p,
                                     input logic signed [PD_W-1:0] a,
                                     input logic signed [PD_W-1:0] b);
        return (p < a && p < b) || (p > a && p > b);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rsr_if.sv =====
// rsr_if: valid/ready channels for ray words in and range words out.
// Depends on rsr_pkg.
`default_nettype none

interface rsr_ray_if import rsr_pkg::*; ();
    logic valid;
    logic ready;
    t_crd ray_origin_x;
    t_crd ray_origin_y;
    t_crd ray_end_x;
    t_crd ray_end_y;

    modport source (output valid, ray_origin_x, ray_origin_y, ray_end_x, ray_end_y,
                    input ready);
    modport sink   (input valid, ray_origin_x, ray_origin_y, ray_end_x, ray_end_y,
                    output ready);
endinterface

interface rsr_rng_if import rsr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [RANGE_W-1:0] range;

    modport source (output valid, hit, range, input ready);
    modport sink   (input valid, hit, range, output ready);
endinterface

`default_nettype wire

// ===== rtl/ray_segment_range.sv =====
// ray_segment_range: range of a ray to one wall segment, one ray word per cycle.
// The pipeline has 56 stages (8 front, 19 divider, 4 distance, 25 root) plus the
// output buffer, which offers the result words.
// Throughput: one word per cycle; the pipeline stalls only when the two-word
// output buffer is full. Synchronous active-low reset clears valid bits,
// buffer count and the segment registers.
`default_nettype none

module ray_segment_range import rsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    rsr_ray_if.sink           i_ray,
    rsr_rng_if.source         o_rng
);

    localparam logic [1:0] OC_EMPTY = 2'd0;
    localparam logic [1:0] OC_ONE   = 2'd1;
    localparam logic [1:0] OC_TWO   = 2'd2;

    t_seg_cfg w_seg;
    logic     w_en;
    logic     w_push, w_pop;
    logic [1:0] r_ocnt;
    t_res     r_oq0, r_oq1, w_res;

    // register file
    rsr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_seg   (w_seg)
    );

    // pipeline advances while the output buffer has room
    assign w_en        = (r_ocnt != OC_TWO);
    assign i_ray.ready = w_en;

    t_ray w_ray;
    assign w_ray.ox = i_ray.ray_origin_x;
    assign w_ray.oy = i_ray.ray_origin_y;
    assign w_ray.ex = i_ray.ray_end_x;
    assign w_ray.ey = i_ray.ray_end_y;

    logic w_frt_vld;
    t_frt w_frt;

    rsr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_ray.valid),
        .i_ray   (w_ray),
        .i_seg   (w_seg),
        .o_vld   (w_frt_vld),
        .o_frt   (w_frt)
    );

    // x and y rounding divisions
    logic           w_dvx_vld, w_dvy_vld, w_dvx_neg, w_dvy_neg;
    logic [Q_W-1:0] w_qx, w_qy;

    rsr_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_frt_vld),
        .i_neg   (w_frt.nx_neg),
        .i_mag   (w_frt.nx_mag),
        .i_dvs   (w_frt.dvs),
        .o_vld   (w_dvx_vld),
        .o_neg   (w_dvx_neg),
        .o_quo   (w_qx)
    );

    rsr_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_frt_vld),
        .i_neg   (w_frt.ny_neg),
        .i_mag   (w_frt.ny_mag),
        .i_dvs   (w_frt.dvs),
        .o_vld   (w_dvy_vld),
        .o_neg   (w_dvy_neg),
        .o_quo   (w_qy)
    );

    // side data delayed to match the dividers
    t_side r_dl [Q_W];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl[0] <= w_frt.side;
            for (int k = 1; k < Q_W; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    // P1: signed rounded point
    logic                   r_p1_vld;
    t_side                  r_p1_side;
    logic signed [PX_W-1:0] r_p1_px, r_p1_py;
    logic signed [PX_W-1:0] w_qxs, w_qys;

    assign w_qxs = $signed({1'b0, w_qx});
    assign w_qys = $signed({1'b0, w_qy});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_side <= r_dl[Q_W-1];
            r_p1_px   <= w_dvx_neg ? -w_qxs : w_qxs;
            r_p1_py   <= w_dvy_neg ? -w_qys : w_qys;
        end
    end

    // P2: span tests and offsets from the origin
    logic signed [PD_W-1:0] w_pxs, w_pys, w_dx, w_dy;
    logic                   w_out;
    logic                   r_p2_vld, r_p2_hit;
    logic signed [DX_W-1:0] r_p2_dx, r_p2_dy;

    assign w_pxs = PD_W'(r_p1_px) <<< FRAC_BITS;
    assign w_pys = PD_W'(r_p1_py) <<< FRAC_BITS;
    assign w_dx  = w_pxs - PD_W'(r_p1_side.ray.ox);
    assign w_dy  = w_pys - PD_W'(r_p1_side.ray.oy);
    assign w_out = outside(PD_W'(r_p1_px), PD_W'(w_seg.sx), PD_W'(w_seg.ex)) ||
                   outside(PD_W'(r_p1_py), PD_W'(w_seg.sy), PD_W'(w_seg.ey)) ||
                   outside(w_pxs, PD_W'(r_p1_side.ray.ox), PD_W'(r_p1_side.ray.ex)) ||
                   outside(w_pys, PD_W'(r_p1_side.ray.oy), PD_W'(r_p1_side.ray.ey));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_hit <= !r_p1_side.miss && !w_out;
            r_p2_dx  <= DX_W'(w_dx);
            r_p2_dy  <= DX_W'(w_dy);
        end
    end

    // P3: squares
    logic                      r_p3_vld, r_p3_hit;
    logic signed [2*DX_W-1:0]  r_p3_sx, r_p3_sy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p3_hit <= r_p2_hit;
            r_p3_sx  <= r_p2_dx * r_p2_dx;
            r_p3_sy  <= r_p2_dy * r_p2_dy;
        end
    end

    // P4: squared distance
    logic               r_p4_vld, r_p4_hit;
    logic [SQ_IN_W-1:0] r_p4_d2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p4_hit <= r_p3_hit;
            r_p4_d2  <= SQ_IN_W'(r_p3_sx[SQ_IN_W-2:0]) + SQ_IN_W'(r_p3_sy[SQ_IN_W-2:0]);
        end
    end

    // valid bits of the distance stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
        end else if (w_en) begin
            r_p1_vld <= w_dvx_vld && w_dvy_vld;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            r_p4_vld <= r_p3_vld;
        end
    end

    // root of the squared distance
    logic                w_sq_vld, w_sq_hit;
    logic [SQ_STEPS-1:0] w_root;

    rsr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_p4_vld),
        .i_tag   (r_p4_hit),
        .i_val   (r_p4_d2),
        .o_vld   (w_sq_vld),
        .o_tag   (w_sq_hit),
        .o_root  (w_root)
    );

    // saturate, zero on a miss
    localparam int SAT_W = SQ_STEPS + RANGE_W;
    logic [RANGE_W-1:0] w_sat;

    assign w_sat = (SAT_W'(w_root) > SAT_W'(RANGE_MAX)) ? RANGE_MAX
                                                       : RANGE_W'(w_root);
    assign w_res.hit   = w_sq_hit;
    assign w_res.range = w_sq_hit ? w_sat : '0;

    // two-word output buffer
    assign w_push = w_en && w_sq_vld;
    assign w_pop  = o_rng.valid && o_rng.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= OC_EMPTY;
        end else begin
            unique case (r_ocnt)
                OC_EMPTY: if (w_push) r_ocnt <= OC_ONE;
                OC_ONE: begin
                    if (w_push && !w_pop) begin
                        r_ocnt <= OC_TWO;
                    end else if (!w_push && w_pop) begin
                        r_ocnt <= OC_EMPTY;
                    end
                end
                OC_TWO: if (w_pop) r_ocnt <= OC_ONE;
                default: r_ocnt <= OC_EMPTY;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_ocnt)
            OC_EMPTY: if (w_push) r_oq0 <= w_res;
            OC_ONE: begin
                if (w_push && w_pop) begin
                    r_oq0 <= w_res;
                end else if (w_push) begin
                    r_oq1 <= w_res;
                end
            end
            OC_TWO: if (w_pop) r_oq0 <= r_oq1;
            default: r_oq0 <= r_oq0;
        endcase
    end

    assign o_rng.valid = (r_ocnt != OC_EMPTY);
    assign o_rng.hit   = r_oq0.hit;
    assign o_rng.range = r_oq0.range;

    // buffer never written while full
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_ocnt != OC_TWO))
        else $error("result pushed into full output buffer");

    // both divider lanes stay in step
    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dvx_vld == w_dvy_vld)
        else $error("divider lanes out of step");

    // a miss reports zero range
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rng.valid && !o_rng.hit) |-> (o_rng.range == '0))
        else $error("miss with nonzero range");

endmodule

`default_nettype wire

// ===== rtl/rsr_cfg.sv =====
// rsr_cfg: APB register file holding the wall segment endpoints.
// Depends on rsr_pkg.
`default_nettype none

module rsr_cfg import rsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_seg_cfg          o_seg
);

    t_seg_cfg   r_seg;
    logic [1:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[APB_AW-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_seg  = r_seg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SEG_SX: r_seg.sx <= pwdata[SEG_W-1:0];
                REG_SEG_SY: r_seg.sy <= pwdata[SEG_W-1:0];
                REG_SEG_EX: r_seg.ex <= pwdata[SEG_W-1:0];
                REG_SEG_EY: r_seg.ey <= pwdata[SEG_W-1:0];
                default:    r_seg    <= r_seg;
            endcase
        end
    end

    // read mux, sign-extended
    always_comb begin
        unique case (w_idx)
            REG_SEG_SX: prdata = APB_DW'(r_seg.sx);
            REG_SEG_SY: prdata = APB_DW'(r_seg.sy);
            REG_SEG_EX: prdata = APB_DW'(r_seg.ex);
            REG_SEG_EY: prdata = APB_DW'(r_seg.ey);
            default:    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/rsr_front.sv =====
// rsr_front: eight-stage front end: box test, cross products, determinant
// normalize, split products and the rounded-coordinate numerators. Uses rsr_pkg.
`default_nettype none

module rsr_front import rsr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_vld,
    input  t_ray     i_ray,
    input  t_seg_cfg i_seg,
    output logic     o_vld,
    output t_frt     o_frt
);

    localparam int FAR_W = ((TN_W > DEN_W) ? TN_W : DEN_W) + 2;
    localparam int DL_W  = HALF_W + 1;
    localparam int DH_W  = DEN_W - HALF_W;
    localparam int TL_W  = HALF_W + 1;
    localparam int TH_W  = TN_W - HALF_W;

    logic [7:0] r_vld;

    // segment deltas; the user must hold the segment static while words are in flight (not enforced)
    logic signed [UX_W-1:0] r_ux, r_uy;

    always_ff @(posedge i_clk) begin
        r_ux <= UX_W'(i_seg.ex) - UX_W'(i_seg.sx);
        r_uy <= UX_W'(i_seg.ey) - UX_W'(i_seg.sy);
    end

    // valid bits for all stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[6:0], i_vld};
        end
    end
    assign o_vld = r_vld[7];

    // stage 1: bounding box test and differences
    logic signed [AX_W-1:0] w_ax, w_ay, w_bx, w_by;
    logic                   w_box;
    t_side                  r1_side;
    logic signed [V_W-1:0]  r1_vx, r1_vy;
    logic signed [W_W-1:0]  r1_wx, r1_wy;

    assign w_ax = AX_W'(i_seg.sx) <<< FRAC_BITS;
    assign w_ay = AX_W'(i_seg.sy) <<< FRAC_BITS;
    assign w_bx = AX_W'(i_seg.ex) <<< FRAC_BITS;
    assign w_by = AX_W'(i_seg.ey) <<< FRAC_BITS;
    assign w_box = box_miss(W_W'(i_ray.ox), W_W'(i_ray.ex), W_W'(w_ax), W_W'(w_bx)) ||
                   box_miss(W_W'(i_ray.oy), W_W'(i_ray.ey), W_W'(w_ay), W_W'(w_by));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side.miss <= w_box;
            r1_side.ray  <= i_ray;
            r1_vx <= V_W'(i_ray.ex) - V_W'(i_ray.ox);
            r1_vy <= V_W'(i_ray.ey) - V_W'(i_ray.oy);
            r1_wx <= W_W'(i_ray.ox) - W_W'(w_ax);
            r1_wy <= W_W'(i_ray.oy) - W_W'(w_ay);
        end
    end

    // stage 2: cross products
    t_side                    r2_side;
    logic signed [TDP_W-1:0]  r2_puv, r2_pvu;
    logic signed [TNP_W-1:0]  r2_pwv, r2_pwu;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side <= r1_side;
            r2_puv  <= r_ux * r1_vy;
            r2_pvu  <= r_uy * r1_vx;
            r2_pwv  <= r1_wx * r1_vy;
            r2_pwu  <= r1_wy * r1_vx;
        end
    end

    // stage 3: determinant and numerator
    logic signed [TDP_W:0]   w_tdd;
    t_side                   r3_side;
    logic signed [DEN_W-1:0] r3_td;
    logic signed [TN_W-1:0]  r3_tn;

    assign w_tdd = (TDP_W+1)'(r2_puv) - (TDP_W+1)'(r2_pvu);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_side <= r2_side;
            r3_td   <= DEN_W'(w_tdd) <<< FRAC_BITS;
            r3_tn   <= TN_W'(r2_pwv) - TN_W'(r2_pwu);
        end
    end

    // stage 4: make the determinant positive; zero means parallel
    logic                    w_tdneg;
    logic signed [DEN_W-1:0] w_tdabs;
    t_side                   r4_side;
    logic [DEN_W-2:0]        r4_den;
    logic signed [TN_W-1:0]  r4_tn;

    assign w_tdneg = r3_td[DEN_W-1];
    assign w_tdabs = w_tdneg ? -r3_td : r3_td;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_side.ray  <= r3_side.ray;
            r4_side.miss <= r3_side.miss || (r3_td == '0);
            r4_den <= w_tdabs[DEN_W-2:0];
            r4_tn  <= w_tdneg ? -r3_tn : r3_tn;
        end
    end

    // stage 5: far reject and split partial products
    logic [TN_W-1:0]         w_tnabs;
    logic [FAR_W-1:0]        w_den3;
    logic signed [DL_W-1:0]  w_dlo;
    logic signed [DH_W-1:0]  w_dhi;
    logic signed [TL_W-1:0]  w_tlo;
    logic signed [TH_W-1:0]  w_thi;
    t_side                   r5_side;
    logic [DEN_W-2:0]        r5_den;
    logic signed [SEG_W+DL_W-1:0] r5_axl, r5_ayl;
    logic signed [SEG_W+DH_W-1:0] r5_axh, r5_ayh;
    logic signed [UX_W+TL_W-1:0]  r5_uxl, r5_uyl;
    logic signed [UX_W+TH_W-1:0]  r5_uxh, r5_uyh;

    assign w_tnabs = r4_tn[TN_W-1] ? -r4_tn : r4_tn;
    assign w_den3  = FAR_W'(r4_den) + (FAR_W'(r4_den) << 1);
    assign w_dlo   = $signed({1'b0, r4_den[HALF_W-1:0]});
    assign w_dhi   = $signed({1'b0, r4_den[DEN_W-2:HALF_W]});
    assign w_tlo   = $signed({1'b0, r4_tn[HALF_W-1:0]});
    assign w_thi   = r4_tn[TN_W-1:HALF_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_side.ray  <= r4_side.ray;
            r5_side.miss <= r4_side.miss || (FAR_W'(w_tnabs) > w_den3);
            r5_den <= r4_den;
            r5_axl <= i_seg.sx * w_dlo;
            r5_axh <= i_seg.sx * w_dhi;
            r5_ayl <= i_seg.sy * w_dlo;
            r5_ayh <= i_seg.sy * w_dhi;
            r5_uxl <= r_ux * w_tlo;
            r5_uxh <= r_ux * w_thi;
            r5_uyl <= r_uy * w_tlo;
            r5_uyh <= r_uy * w_thi;
        end
    end

    // stage 6: recombine a*den and u*tn
    t_side               r6_side;
    logic [DEN_W-2:0]    r6_den;
    logic signed [N_W-1:0] r6_ax, r6_ay, r6_ux, r6_uy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_side <= r5_side;
            r6_den  <= r5_den;
            r6_ax <= (N_W'(r5_axh) <<< HALF_W) + N_W'(r5_axl);
            r6_ay <= (N_W'(r5_ayh) <<< HALF_W) + N_W'(r5_ayl);
            r6_ux <= (N_W'(r5_uxh) <<< HALF_W) + N_W'(r5_uxl);
            r6_uy <= (N_W'(r5_uyh) <<< HALF_W) + N_W'(r5_uyl);
        end
    end

    // stage 7: numerator 2a*den + 2u*tn + den
    logic signed [N_W-1:0] w_den_n;
    t_side                 r7_side;
    logic [DEN_W-2:0]      r7_den;
    logic signed [N_W-1:0] r7_nx, r7_ny;

    assign w_den_n = $signed(N_W'(r6_den));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_side <= r6_side;
            r7_den  <= r6_den;
            r7_nx <= (r6_ax <<< 1) + (r6_ux <<< 1) + w_den_n;
            r7_ny <= (r6_ay <<< 1) + (r6_uy <<< 1) + w_den_n;
        end
    end

    // stage 8: sign and magnitude for the dividers
    logic signed [N_W-1:0] w_nxabs, w_nyabs;
    t_frt                  r8_frt;

    assign w_nxabs = r7_nx[N_W-1] ? -r7_nx : r7_nx;
    assign w_nyabs = r7_ny[N_W-1] ? -r7_ny : r7_ny;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_frt.side   <= r7_side;
            r8_frt.nx_neg <= r7_nx[N_W-1];
            r8_frt.nx_mag <= w_nxabs[NMAG_W-1:0];
            r8_frt.ny_neg <= r7_ny[N_W-1];
            r8_frt.ny_mag <= w_nyabs[NMAG_W-1:0];
            r8_frt.dvs    <= {r7_den, 1'b0};
        end
    end
    assign o_frt = r8_frt;

endmodule

`default_nettype wire

// ===== rtl/rsr_div.sv =====
// rsr_div: pipelined restoring divider, one quotient bit per stage.
// Quotient magnitude is known to fit Q_W bits. Uses rsr_pkg.
`default_nettype none

module rsr_div import rsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic              i_neg,
    input  logic [NMAG_W-1:0] i_mag,
    input  logic [DEN_W-1:0]  i_dvs,
    output logic              o_vld,
    output logic              o_neg,
    output logic [Q_W-1:0]    o_quo
);

    logic              r_vld [Q_W];
    logic              r_neg [Q_W];
    logic [NMAG_W-1:0] r_rem [Q_W];
    logic [DEN_W-1:0]  r_dvs [Q_W];
    logic [Q_W-1:0]    r_quo [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stg
        localparam int B = Q_W - 1 - s;
        logic              w_vld, w_neg, w_ge;
        logic [NMAG_W-1:0] w_rem, w_sub;
        logic [DEN_W-1:0]  w_dvs;
        logic [Q_W-1:0]    w_quo;

        if (s == 0) begin : g_head
            assign w_vld = i_vld;
            assign w_neg = i_neg;
            assign w_rem = i_mag;
            assign w_dvs = i_dvs;
            assign w_quo = '0;
        end else begin : g_body
            assign w_vld = r_vld[s-1];
            assign w_neg = r_neg[s-1];
            assign w_rem = r_rem[s-1];
            assign w_dvs = r_dvs[s-1];
            assign w_quo = r_quo[s-1];
        end

        // trial subtract of the shifted divisor
        assign w_sub = NMAG_W'(w_dvs) << B;
        assign w_ge  = (w_rem >= w_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[s] <= w_neg;
                r_dvs[s] <= w_dvs;
                r_rem[s] <= w_ge ? (w_rem - w_sub) : w_rem;
                r_quo[s] <= w_quo | (Q_W'(w_ge) << B);
            end
        end
    end

    assign o_vld = r_vld[Q_W-1];
    assign o_neg = r_neg[Q_W-1];
    assign o_quo = r_quo[Q_W-1];

endmodule

`default_nettype wire

// ===== rtl/rsr_sqrt.sv =====
// rsr_sqrt: pipelined integer square root, one result bit per stage, with
// a one-bit tag carried alongside. Uses rsr_pkg.
`default_nettype none

module rsr_sqrt import rsr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic               i_tag,
    input  logic [SQ_IN_W-1:0] i_val,
    output logic               o_vld,
    output logic               o_tag,
    output logic [SQ_STEPS-1:0] o_root
);

    logic               r_vld [SQ_STEPS];
    logic               r_tag [SQ_STEPS];
    logic [SQ_IN_W-1:0] r_v   [SQ_STEPS];
    logic [SQ_R_W-1:0]  r_res [SQ_STEPS];

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_stg
        localparam logic [SQ_R_W-1:0] B = SQ_R_W'(1) << (2 * (SQ_STEPS - 1 - s));
        logic               w_vld, w_tag, w_ge;
        logic [SQ_IN_W-1:0] w_v;
        logic [SQ_R_W-1:0]  w_res, w_trial, w_diff;

        if (s == 0) begin : g_head
            assign w_vld = i_vld;
            assign w_tag = i_tag;
            assign w_v   = i_val;
            assign w_res = '0;
        end else begin : g_body
            assign w_vld = r_vld[s-1];
            assign w_tag = r_tag[s-1];
            assign w_v   = r_v[s-1];
            assign w_res = r_res[s-1];
        end

        // one digit of the root
        assign w_trial = w_res + B;
        assign w_ge    = ({1'b0, w_v} >= w_trial);
        assign w_diff  = {1'b0, w_v} - w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[s] <= w_tag;
                r_v[s]   <= w_ge ? w_diff[SQ_IN_W-1:0] : w_v;
                r_res[s] <= w_ge ? ((w_res >> 1) + B) : (w_res >> 1);
            end
        end
    end

    assign o_vld  = r_vld[SQ_STEPS-1];
    assign o_tag  = r_tag[SQ_STEPS-1];
    assign o_root = r_res[SQ_STEPS-1][SQ_STEPS-1:0];

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench: self-checking bench for ray_segment_range (ray words in, range words out).
// Depends on rsr_pkg, rsr_if and the ray_segment_range RTL.
`default_nettype none

// Scoreboard: predicts the range word for each accepted ray and checks results.
class range_scoreboard;
    logic signed [15:0] seg_sx, seg_sy, seg_ex, seg_ey;
    logic               hit_q[$];
    logic [24:0]        rng_q[$];
    int                 n_fail;
    int                 n_rays;
    int                 n_hits;

    function void clear_segment();
        seg_sx = 0; seg_sy = 0; seg_ex = 0; seg_ey = 0;
        n_fail = 0; n_rays = 0; n_hits = 0;
    endfunction

    function void set_reg(int idx, logic [15:0] v);
        case (idx)
            rsr_pkg::REG_SEG_SX: seg_sx = v;
            rsr_pkg::REG_SEG_SY: seg_sy = v;
            rsr_pkg::REG_SEG_EX: seg_ex = v;
            rsr_pkg::REG_SEG_EY: seg_ey = v;
            default: ;
        endcase
    endfunction

    static function bit beyond(longint p, longint a, longint b);
        return (p < a && p < b) || (p > a && p > b);
    endfunction

    static function bit box_out(longint o, longint e, longint a, longint b);
        return (o < a && o < b && e < a && e < b) || (o > a && o > b && e > a && e > b);
    endfunction

    // trunc(a + u*tn/den + 1/2) with den > 0, exact in 128 bits
    static function longint snap_coord(longint a, longint u, longint tn, longint den);
        logic signed [127:0] num;
        logic signed [127:0] q;
        num = 128'(signed'(2 * a)) * 128'(signed'(den))
            + 128'(signed'(2 * u)) * 128'(signed'(tn)) + 128'(signed'(den));
        q = num / 128'(signed'(2 * den));
        return longint'(q);
    endfunction

    static function longint root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            b = r | (64'd1 << i);
            if (b * b <= v) r = b;
        end
        return longint'(r);
    endfunction

    function void note_ray(logic signed [23:0] rox, logic signed [23:0] roy,
                           logic signed [23:0] rex, logic signed [23:0] rey);
        longint ox, oy, ex, ey, ax, ay, bx, by, ux, uy, vx, vy, wx, wy;
        longint td, tn, px, py, dx, dy, r;
        logic hit;
        ox = rox; oy = roy; ex = rex; ey = rey;
        ax = longint'(seg_sx) * 256; ay = longint'(seg_sy) * 256;
        bx = longint'(seg_ex) * 256; by = longint'(seg_ey) * 256;
        hit = 0; r = 0;
        n_rays++;
        if (!box_out(ox, ex, ax, bx) && !box_out(oy, ey, ay, by)) begin
            ux = seg_ex - seg_sx; uy = seg_ey - seg_sy;
            vx = ex - ox; vy = ey - oy;
            wx = ox - ax; wy = oy - ay;
            td = (ux * vy - uy * vx) * 256;
            tn = wx * vy - wy * vx;
            if (td != 0) begin
                if (td < 0) begin
                    td = -td; tn = -tn;
                end
                if (!(tn > 3 * td || -tn > 3 * td)) begin
                    px = snap_coord(seg_sx, ux, tn, td);
                    py = snap_coord(seg_sy, uy, tn, td);
                    if (!beyond(px, seg_sx, seg_ex) && !beyond(py, seg_sy, seg_ey)) begin
                        px *= 256; py *= 256;
                        if (!beyond(px, ox, ex) && !beyond(py, oy, ey)) begin
                            dx = px - ox; dy = py - oy;
                            r = root_floor(dx * dx + dy * dy);
                            if (r > 33554431) r = 33554431;
                            hit = 1;
                        end
                    end
                end
            end
        end
        if (hit) n_hits++;
        hit_q.push_back(hit);
        rng_q.push_back(25'(r));
    endfunction

    function void check_range(logic hit, logic [24:0] rng);
        logic       eh;
        logic [24:0] er;
        if (hit_q.size() == 0) begin
            $error("unexpected range word hit=%0d range=%0d", hit, rng);
            n_fail++;
            return;
        end
        eh = hit_q.pop_front();
        er = rng_q.pop_front();
        if (hit !== eh) begin
            $error("hit: expected %0d actual %0d", eh, hit);
            n_fail++;
        end
        if (rng !== er) begin
            $error("range: expected %0d actual %0d", er, rng);
            n_fail++;
        end
    endfunction
endclass

module testbench import rsr_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 57;
    localparam longint CYCLE_LIMIT = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    longint            cycles;
    bit                stall_mode;

    rsr_ray_if ray_ch ();
    rsr_rng_if rng_ch ();
    range_scoreboard sb;

    ray_segment_range dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_ray   (ray_ch.sink),
        .o_rng   (rng_ch.source)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
        sb.clear_segment();
    end

    // cycle limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver: stall pattern, switched per phase; result words checked at the edge
    initial begin
        int k;
        k = 0;
        rng_ch.ready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rng_ch.valid && rng_ch.ready)
                sb.check_range(rng_ch.hit, rng_ch.range);
            k++;
            if (!stall_mode) rng_ch.ready <= 1'b1;
            else rng_ch.ready <= ((k % 7) < 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_reg(int idx, logic signed [15:0] v);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= APB_AW'(4 * idx); pwdata <= APB_DW'(v);
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, v);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic set_segment(logic signed [15:0] sx, logic signed [15:0] sy,
                               logic signed [15:0] ex, logic signed [15:0] ey);
        write_reg(REG_SEG_SX, sx);
        write_reg(REG_SEG_SY, sy);
        write_reg(REG_SEG_EX, ex);
        write_reg(REG_SEG_EY, ey);
    endtask

    // one ray word; holds valid until accepted
    task automatic send_ray(t_crd ox, t_crd oy, t_crd ex, t_crd ey);
        ray_ch.valid <= 1; ray_ch.ray_origin_x <= ox; ray_ch.ray_origin_y <= oy;
        ray_ch.ray_end_x <= ex; ray_ch.ray_end_y <= ey;
        @(posedge i_clk);
        while (!ray_ch.ready) @(posedge i_clk);
        sb.note_ray(ox, oy, ex, ey);
    endtask

    task automatic gap();
        if ($urandom_range(0, 3) == 0) begin
            ray_ch.valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // stop sending and wait until every expected word has come back
    task automatic drain();
        ray_ch.valid <= 0;
        while (sb.hit_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic t_crd rnd_crd();
        case ($urandom_range(0, 3))
            0: return t_crd'($urandom);
            1: return t_crd'($urandom_range(0, 1) ? 24'h7fffff : 24'h800000);
            default: return t_crd'(int'($urandom_range(0, 40000)) - 20000) <<< 8;
        endcase
    endfunction

    function automatic logic signed [15:0] rnd_seg(bit wide);
        if (wide) return 16'($urandom);
        return 16'(int'($urandom_range(0, 200)) - 100);
    endfunction

    // ray built to cross the segment: spans a point near the segment's middle
    task automatic send_aimed(int scale);
        longint mx, my, ox, oy;
        mx = (longint'(sb.seg_sx) + sb.seg_ex) * 128 + $urandom_range(0, 511) - 256;
        my = (longint'(sb.seg_sy) + sb.seg_ey) * 128 + $urandom_range(0, 511) - 256;
        ox = mx + int'($urandom_range(0, 2 * scale)) - scale;
        oy = my + int'($urandom_range(0, 2 * scale)) - scale;
        send_ray(t_crd'(ox), t_crd'(oy), t_crd'(2 * mx - ox), t_crd'(2 * my - oy));
    endtask

    initial begin
        int burst;
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        ray_ch.valid = 0;
        ray_ch.ray_origin_x = 0; ray_ch.ray_origin_y = 0;
        ray_ch.ray_end_x = 0; ray_ch.ray_end_y = 0;
        stall_mode = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset segment is a point: every ray misses
        send_ray(-256, -256, 256, 256);
        drain();

        // directed: horizontal segment, zero-coordinate crossing, parallel, extremes
        set_segment(-10, 0, 10, 0);
        send_ray(0, -2560, 0, 2560);               // hits at origin
        send_ray(-512, -512, 768, 1024);           // crossing near x = 0
        send_ray(-2560, 256, 2560, 256);           // parallel to segment
        send_ray(256, 256, 256, 256);              // ray of zero length
        send_ray(5000, 5000, 6000, 6000);          // box miss
        send_ray(1280, -100, 1290, 100);           // rounds onto x = 5, inside the span
        send_ray(24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000);
        send_ray(24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh800000);
        send_ray(0, 24'sh7fffff, 0, 24'sh800000);
        send_ray(-3000, -100, -2000, 100);         // crosses inside the span near its -x end
        drain();
        set_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_ray(24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh800000);
        send_ray(24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff);
        send_ray(0, 0, 24'sh7fffff, 24'sh7fffff);
        send_ray(-256, 256, 256, -256);
        send_ray(24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff);
        drain();
        set_segment(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_ray(24'sh800000, 0, 24'sh7fffff, 0);
        send_ray(24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh7fffff);
        drain();

        // random phases, each with its own segment
        for (int ph = 0; ph < 12; ph++) begin
            stall_mode = ph[0];
            set_segment(rnd_seg(ph % 3 == 2), rnd_seg(ph % 3 == 2),
                        rnd_seg(ph % 3 == 2), rnd_seg(ph % 3 == 2));
            burst = 0;
            for (int n = 0; n < 78; n++) begin
                case ($urandom_range(0, 9))
                    0, 1: send_ray(rnd_crd(), rnd_crd(), rnd_crd(), rnd_crd());
                    2: send_aimed(8388607);
                    default: send_aimed(ph % 3 == 2 ? 2000000 : 40000);
                endcase
                burst++;
                if (burst > 4 && ph != 4) begin
                    gap();
                    burst = 0;
                end
            end
            ray_ch.valid <= 0;
            drain();
        end

        $display("covered %0d rays over several wall segments, %0d of them hits",
                 sb.n_rays, sb.n_hits);
        if (sb.n_fail == 0 && sb.hit_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire
